/* rtl/grc_pkg.sv */
// Package: shared types and constants for the grid ray-cast column unit.
`timescale 1ns / 1ps
package grc_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RCPX,
        S_RCPY,
        S_SIDEX,
        S_SIDEY,
        S_SIDEW,
        S_STEP,
        S_LOOK,
        S_PERP,
        S_HGT,
        S_FRAC,
        S_DONE
    } t_state;

    // Configuration register indexes (byte address / 4)
    localparam logic [1:0] REG_POS_X = 2'd0;
    localparam logic [1:0] REG_POS_Y = 2'd1;
    localparam logic [1:0] REG_ROWS  = 2'd2;

    // Item kinds
    localparam logic KIND_MAP  = 1'b0;
    localparam logic KIND_CAST = 1'b1;

    // Distances are Q8.16, saturated
    localparam logic [23:0] DIST_MAX = 24'hFFFFFF;

    // Shared restoring divider: 31-bit dividend, 24-bit divisor
    localparam int unsigned DIV_BITS = 31;
    localparam logic [30:0] RCP_NUM  = 31'h4000_0000;  // 1.0 in Q2.14 times 1.0 in Q8.16

    // Register reset values
    localparam logic [21:0] POS_RESET  = 22'd2097152;
    localparam logic [11:0] ROWS_RESET = 12'd480;

endpackage

/* rtl/grid_ray_cast_column_unit.sv */
// Top level: grid ray-cast column unit with wall bitmap, DDA walker and shared divider.
`timescale 1ns / 1ps
// Holds a MAP_SIZE x MAP_SIZE wall bitmap in a single-port-write memory and casts one
// ray per cast transaction from the player's cell. After reset the bitmap is swept to
// zero, one cell per cycle; no transaction is taken during that sweep, configuration
// writes are. A map transaction is written in the cycle it is accepted, so map
// transactions can follow back to back. A cast is accepted, then computes the two
// reciprocals, the first side distances, up to MAX_STEPS DDA steps (step, then
// registered bitmap read), the distance, the height division, then the wall fraction
// and column extent. The one restoring divider computes one quotient bit per cycle.
// One item is in flight at a time; a finished result waits in the output register
// while the next item is taken.
module grid_ray_cast_column_unit
    import grc_pkg::*;
#(
    parameter int MAP_SIZE  = 64,
    parameter int MAX_STEPS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [5:0]  i_cell_row,
    input  logic [5:0]  i_cell_col,
    input  logic        i_cell_is_wall,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_hit_row,
    output logic [5:0]  o_hit_col,
    output logic        o_hit_side,
    output logic [23:0] o_perp_dist,
    output logic [15:0] o_column_height,
    output logic [10:0] o_draw_top,
    output logic [10:0] o_draw_bottom,
    output logic [15:0] o_wall_frac,
    output logic        o_no_hit
);

    localparam int CW        = $clog2(MAP_SIZE);
    localparam int AW        = 2 * CW;
    localparam int MAP_DEPTH = 1 << AW;
    localparam int MW        = CW + 2;
    localparam int SW        = $clog2(MAX_STEPS + 1);

    // ---------------- configuration registers ----------------
    logic [21:0] r_pos_x, r_pos_y;
    logic [11:0] r_rows;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= POS_RESET;
            r_pos_y <= POS_RESET;
            r_rows  <= ROWS_RESET;
        end else if (cfg_we) begin
            case (paddr[3:2])
                REG_POS_X: r_pos_x <= pwdata[21:0];
                REG_POS_Y: r_pos_y <= pwdata[21:0];
                REG_ROWS:  r_rows  <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_POS_X: prdata = {10'd0, r_pos_x};
            REG_POS_Y: prdata = {10'd0, r_pos_y};
            REG_ROWS:  prdata = {20'd0, r_rows};
            default:   prdata = 32'd0;
        endcase
    end

    // ---------------- state and working registers ----------------
    t_state r_state, n_state;

    logic signed [15:0] r_dir_x, r_dir_y;
    logic signed [MW-1:0] r_mx, r_my, n_mx, n_my;
    logic [23:0] r_dx, r_dy, r_sdx, r_sdy, r_perp;
    logic [23:0] n_dx, n_dy, n_sdx, n_sdy, n_perp;
    logic        r_side, n_side, r_nohit, n_nohit;
    logic [SW-1:0] r_steps, n_steps;
    logic [15:0] r_h, n_h, r_frac, n_frac;
    logic [10:0] r_top, n_top, r_bot, n_bot;
    logic [AW-1:0] r_clr;

    // shared divider
    logic [30:0] r_quo, n_quo;
    logic [23:0] r_rem, n_rem, r_dvs, n_dvs;
    logic [4:0]  r_dcnt, n_dcnt;
    logic [24:0] div_sh;
    logic        div_ge;
    logic [30:0] div_quo;
    logic [23:0] div_rem;
    logic        div_busy;
    logic [23:0] rcp_sat;

    // shared multiplier
    logic [23:0] mul_a;
    logic [16:0] mul_b;
    logic [40:0] r_prod, n_prod;

    // bitmap memory
    logic          r_map [MAP_DEPTH];
    logic          r_rd;
    logic          mem_we, mem_wd;
    logic [AW-1:0] mem_wa, mem_ra;

    // misc combinational
    logic        in_acc, out_free;
    logic        start_out;
    logic [15:0] mag_x, mag_y, mag_o;
    logic [16:0] frac_x, frac_y;
    logic [24:0] side_p;
    logic [24:0] sum_x, sum_y;
    logic        oob;
    logic        step_x;
    logic [41:0] pdir;
    logic signed [16:0] top_s;
    logic [15:0] bot_u;
    logic [11:0] bot_c;

    assign in_acc     = i_in_valid & ~o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = ~o_out_valid | ~i_out_stall;
    assign start_out  = (r_state == S_DONE) & out_free;

    // direction magnitudes (0x8000 stays 0x8000)
    assign mag_x = r_dir_x[15] ? 16'(-r_dir_x) : r_dir_x;
    assign mag_y = r_dir_y[15] ? 16'(-r_dir_y) : r_dir_y;
    assign mag_o = r_side ? mag_x : mag_y;

    // fraction to the first boundary, Q1.16 up to 1.0
    assign frac_x = r_dir_x[15] ? {1'b0, r_pos_x[15:0]} : 17'h10000 - {1'b0, r_pos_x[15:0]};
    assign frac_y = r_dir_y[15] ? {1'b0, r_pos_y[15:0]} : 17'h10000 - {1'b0, r_pos_y[15:0]};

    // divider step: one quotient bit per cycle
    assign div_sh   = {r_rem, r_quo[30]};
    assign div_ge   = (div_sh >= {1'b0, r_dvs});
    assign div_rem  = div_ge ? 24'(div_sh - {1'b0, r_dvs}) : div_sh[23:0];
    assign div_quo  = {r_quo[29:0], div_ge};
    assign div_busy = (r_dcnt != 5'd0);
    assign rcp_sat  = (|r_quo[30:24]) ? DIST_MAX : r_quo[23:0];

    // multiplier operand select
    always_comb begin
        case (r_state)
            S_SIDEX: begin mul_a = r_dx;   mul_b = frac_x; end
            S_SIDEY: begin mul_a = r_dy;   mul_b = frac_y; end
            default: begin mul_a = r_perp; mul_b = {1'b0, mag_o}; end
        endcase
    end

    assign side_p = (|r_prod[40:40]) ? 25'h1FFFFFF : r_prod[40:16];
    assign sum_x  = {1'b0, r_sdx} + {1'b0, r_dx};
    assign sum_y  = {1'b0, r_sdy} + {1'b0, r_dy};
    assign step_x = (r_sdx < r_sdy);

    // next-state logic
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == '1) n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc) begin
                    if (i_kind == KIND_MAP) begin
                        n_state = S_IDLE;
                    end else if ((32'(r_pos_x[21:16]) >= MAP_SIZE)
                                 || (32'(r_pos_y[21:16]) >= MAP_SIZE)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RCPX;
                    end
                end
            end
            S_RCPX:  if (!div_busy) n_state = S_RCPY;
            S_RCPY:  if (!div_busy) n_state = S_SIDEX;
            S_SIDEX: n_state = S_SIDEY;
            S_SIDEY: n_state = S_SIDEW;
            S_SIDEW: n_state = S_STEP;
            S_STEP:  n_state = oob ? S_DONE : S_LOOK;
            S_LOOK: begin
                if (r_rd) n_state = S_PERP;
                else if (r_steps == SW'(MAX_STEPS)) n_state = S_DONE;
                else n_state = S_STEP;
            end
            S_PERP:  n_state = S_HGT;
            S_HGT:   if (!div_busy) n_state = S_FRAC;
            S_FRAC:  n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_mx    = r_mx;
        n_my    = r_my;
        n_dx    = r_dx;
        n_dy    = r_dy;
        n_sdx   = r_sdx;
        n_sdy   = r_sdy;
        n_perp  = r_perp;
        n_side  = r_side;
        n_nohit = r_nohit;
        n_steps = r_steps;
        n_h     = r_h;
        n_frac  = r_frac;
        n_top   = r_top;
        n_bot   = r_bot;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_dcnt  = r_dcnt;
        n_prod  = r_prod;
        oob     = 1'b0;
        pdir    = 42'd0;
        top_s   = 17'sd0;
        bot_u   = 16'd0;
        bot_c   = 12'd0;
        mem_we  = 1'b0;
        mem_wd  = 1'b0;
        mem_wa  = r_clr;
        mem_ra  = {r_mx[CW-1:0], r_my[CW-1:0]};

        // iterate the shared divider while it has bits left
        if (div_busy) begin
            n_quo  = div_quo;
            n_rem  = div_rem;
            n_dcnt = r_dcnt - 5'd1;
        end

        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
            end
            S_IDLE: begin
                if (in_acc && i_kind == KIND_MAP) begin
                    mem_we = (32'(i_cell_row) < MAP_SIZE) && (32'(i_cell_col) < MAP_SIZE);
                    mem_wd = i_cell_is_wall;
                    mem_wa = {CW'(i_cell_row), CW'(i_cell_col)};
                end
                if (in_acc && i_kind == KIND_CAST) begin
                    n_mx    = MW'(r_pos_x[21:16]);
                    n_my    = MW'(r_pos_y[21:16]);
                    n_steps = '0;
                    n_side  = 1'b0;
                    n_nohit = (32'(r_pos_x[21:16]) >= MAP_SIZE)
                              || (32'(r_pos_y[21:16]) >= MAP_SIZE);
                    // reciprocal of |dir_x|; a zero divisor saturates on its own
                    n_quo   = RCP_NUM;
                    n_rem   = '0;
                    n_dvs   = {8'd0, (i_dir_x[15] ? 16'(-i_dir_x) : i_dir_x)};
                    n_dcnt  = 5'(DIV_BITS);
                end
            end
            S_RCPX: begin
                if (!div_busy) begin
                    n_dx   = rcp_sat;
                    n_quo  = RCP_NUM;
                    n_rem  = '0;
                    n_dvs  = {8'd0, mag_y};
                    n_dcnt = 5'(DIV_BITS);
                end
            end
            S_RCPY: begin
                if (!div_busy) n_dy = rcp_sat;
            end
            S_SIDEX: begin
                n_prod = mul_a * mul_b;
            end
            S_SIDEY: begin
                n_sdx  = (|side_p[24]) ? DIST_MAX : side_p[23:0];
                n_prod = mul_a * mul_b;
            end
            S_SIDEW: begin
                n_sdy = (|side_p[24]) ? DIST_MAX : side_p[23:0];
            end
            S_STEP: begin
                // one DDA step; ties step the second axis
                n_steps = r_steps + SW'(1);
                if (step_x) begin
                    n_sdx  = sum_x[24] ? DIST_MAX : sum_x[23:0];
                    n_mx   = r_dir_x[15] ? r_mx - MW'(1) : r_mx + MW'(1);
                    n_side = 1'b0;
                end else begin
                    n_sdy  = sum_y[24] ? DIST_MAX : sum_y[23:0];
                    n_my   = r_dir_y[15] ? r_my - MW'(1) : r_my + MW'(1);
                    n_side = 1'b1;
                end
                oob = (n_mx < 0) || (n_my < 0)
                      || (n_mx >= MW'(MAP_SIZE)) || (n_my >= MW'(MAP_SIZE));
                if (oob) n_nohit = 1'b1;
                mem_ra = {n_mx[CW-1:0], n_my[CW-1:0]};
            end
            S_LOOK: begin
                if (!r_rd && r_steps == SW'(MAX_STEPS)) n_nohit = 1'b1;
            end
            S_PERP: begin
                if (r_side == 1'b0) n_perp = (r_sdx >= r_dx) ? r_sdx - r_dx : 24'd0;
                else                n_perp = (r_sdy >= r_dy) ? r_sdy - r_dy : 24'd0;
                // column height: (rows << 16) / perp, zero distance saturates
                n_quo  = {3'd0, r_rows, 16'd0};
                n_rem  = '0;
                n_dvs  = n_perp;
                n_dcnt = 5'(DIV_BITS);
            end
            S_HGT: begin
                if (!div_busy) begin
                    n_h    = (|r_quo[30:16]) ? 16'hFFFF : r_quo[15:0];
                    n_prod = mul_a * mul_b;
                end
            end
            S_FRAC: begin
                // hit position along the wall on the other axis
                pdir   = (r_side ? r_dir_x[15] : r_dir_y[15]) ? 42'(-{1'b0, r_prod})
                                                              : {1'b0, r_prod};
                n_frac = (r_side ? r_pos_x[15:0] : r_pos_y[15:0]) + pdir[29:14];
                // projected column extent
                top_s  = $signed({6'd0, r_rows[11:1]}) - $signed({2'd0, r_h[15:1]});
                n_top  = top_s[16] ? 11'd0 : top_s[10:0];
                bot_u  = {1'b0, r_h[15:1]} + {5'd0, r_rows[11:1]};
                if (r_rows == 12'd0)                bot_c = 12'd0;
                else if (bot_u >= {4'd0, r_rows})   bot_c = r_rows - 12'd1;
                else                                bot_c = bot_u[11:0];
                n_bot  = bot_c[11] ? 11'd2047 : bot_c[10:0];
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_dcnt      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dcnt  <= n_dcnt;
            if (r_state == S_CLEAR) r_clr <= r_clr + AW'(1);
            if (start_out) o_out_valid <= 1'b1;
            else if (!i_out_stall) o_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mx    <= n_mx;
        r_my    <= n_my;
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_sdx   <= n_sdx;
        r_sdy   <= n_sdy;
        r_perp  <= n_perp;
        r_side  <= n_side;
        r_nohit <= n_nohit;
        r_steps <= n_steps;
        r_h     <= n_h;
        r_frac  <= n_frac;
        r_top   <= n_top;
        r_bot   <= n_bot;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_dvs   <= n_dvs;
        r_prod  <= n_prod;
        if (in_acc && i_kind == KIND_CAST) begin
            r_dir_x <= i_dir_x;
            r_dir_y <= i_dir_y;
        end
    end

    // wall bitmap
    always_ff @(posedge i_clk) begin
        if (mem_we) r_map[mem_wa] <= mem_wd;
        r_rd <= r_map[mem_ra];
    end

    // output register; a missed ray reports zeros
    always_ff @(posedge i_clk) begin
        if (start_out) begin
            o_no_hit        <= r_nohit;
            o_hit_row       <= r_nohit ? 6'd0  : 6'(r_mx);
            o_hit_col       <= r_nohit ? 6'd0  : 6'(r_my);
            o_hit_side      <= r_nohit ? 1'b0  : r_side;
            o_perp_dist     <= r_nohit ? 24'd0 : r_perp;
            o_column_height <= r_nohit ? 16'd0 : r_h;
            o_draw_top      <= r_nohit ? 11'd0 : r_top;
            o_draw_bottom   <= r_nohit ? 11'd0 : r_bot;
            o_wall_frac     <= r_nohit ? 16'd0 : r_frac;
        end
    end

endmodule
